@@ sv/v3n_pkg.sv @@
`timescale 1ns / 1ps

package v3n_pkg;

   // vector components per word
   localparam int unsigned NumComp = 3;

endpackage

@@ sv/vector3_normalize.sv @@
`timescale 1ns / 1ps

// Three-component vector normalizer, fixed point.
// req_ (slave) stream: one word per vector. tdata holds x, y, z, each a
// signed IN_WIDTH-bit Q4.12 value, x in the lowest bits, zero padded to bytes.
// rsp_ (master) stream: one word per input word, in order. tdata holds
// unit_x, unit_y, unit_z, each a signed Q1.OUT_FRAC_BITS value of
// OUT_FRAC_BITS+2 bits, truncated toward zero; tuser is was_null, set when
// the input was the zero vector (components then read zero).
// Datapath: magnitude/sign, squaring, sum and scale, then one register stage
// per root bit of the square root (IN_WIDTH+OUT_FRAC_BITS stages), then one
// stage per quotient bit of the three parallel restoring dividers
// (OUT_FRAC_BITS+1 stages), then the output register.
// A word runs from req_tdata to rsp_tvalid through
// IN_WIDTH + 2*OUT_FRAC_BITS + 5 register stages.
// Throughput: one word per cycle while not stalled; every stage holds its own.
// A stall on rsp_tready freezes the whole pipe while the output register is
// full; req_tready drops with it, so nothing is lost or repeated. An empty
// output register never blocks: the pipe moves whenever the output is free.
// Reset clears all valid bits; the data path carries no reset.
module vector3_normalize
   import v3n_pkg::*;
#(
   parameter int unsigned IN_WIDTH      = 16,
   parameter int unsigned OUT_FRAC_BITS = 14,
   localparam int unsigned ReqDw = ((NumComp * IN_WIDTH + 7) / 8) * 8,
   localparam int unsigned OutW  = OUT_FRAC_BITS + 2,
   localparam int unsigned RspDw = ((NumComp * OutW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ReqDw-1:0] req_tdata,   // x_in, y_in, z_in, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RspDw-1:0] rsp_tdata,   // unit_x, unit_y, unit_z, zero pad
   output logic             rsp_tuser    // was_null
);

   localparam int unsigned W   = IN_WIDTH;
   localparam int unsigned F   = OUT_FRAC_BITS;
   localparam int unsigned SW  = 2 * W;          // sum of squares
   localparam int unsigned RW  = W + F;          // root width
   localparam int unsigned VW  = 2 * RW;         // radicand width
   localparam int unsigned NW  = W + 2 * F;      // dividend width
   localparam int unsigned QW  = F + 1;          // quotient width
   localparam int unsigned DS  = F + 1;          // divider stages

   typedef logic [W-1:0] mag_type [NumComp];

   logic adv;
   logic out_valid_ff;

   assign adv        = ~out_valid_ff | rsp_tready;
   assign req_tready = adv;

   // ---- front: magnitude, square, sum ----
   logic              f0_valid_ff, f1_valid_ff, f2_valid_ff;
   mag_type           f0_mag_ff, f1_mag_ff, f2_mag_ff;
   logic [NumComp-1:0] f0_neg_ff, f1_neg_ff, f2_neg_ff;
   logic [SW-1:0]     f1_sq_ff [NumComp];
   logic [VW-1:0]     f2_v_ff;
   logic              f2_null_ff;
   mag_type           f0_mag_in;
   logic [NumComp-1:0] f0_neg_in;
   logic [SW-1:0]     sum_in;

   always_comb begin
      for (int k = 0; k < NumComp; k++) begin
         f0_neg_in[k] = req_tdata[k*W + W-1];
         f0_mag_in[k] = f0_neg_in[k] ? (~req_tdata[k*W +: W] + W'(1))
                                     : req_tdata[k*W +: W];
      end
      sum_in = f1_sq_ff[0] + f1_sq_ff[1] + f1_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f0_valid_ff <= req_tvalid;
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f0_mag_ff <= f0_mag_in;
         f0_neg_ff <= f0_neg_in;
         for (int k = 0; k < NumComp; k++) begin
            f1_sq_ff[k] <= SW'(f0_mag_ff[k]) * SW'(f0_mag_ff[k]);
         end
         f1_mag_ff  <= f0_mag_ff;
         f1_neg_ff  <= f0_neg_ff;
         f2_v_ff    <= {sum_in, (2*F)'(0)};
         f2_null_ff <= (sum_in == '0);
         f2_mag_ff  <= f1_mag_ff;
         f2_neg_ff  <= f1_neg_ff;
      end
   end

   // ---- square root, one root bit per stage ----
   logic               sq_valid_ff [1:RW];
   logic [VW-1:0]      sq_v_ff     [1:RW];
   logic [RW+1:0]      sq_rem_ff   [1:RW];
   logic [RW-1:0]      sq_root_ff  [1:RW];
   mag_type            sq_mag_ff   [1:RW];
   logic [NumComp-1:0] sq_neg_ff   [1:RW];
   logic               sq_null_ff  [1:RW];

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      logic               valid_src;
      logic [VW-1:0]      v_src;
      logic [RW+1:0]      rem_src;
      logic [RW-1:0]      root_src;
      mag_type            mag_src;
      logic [NumComp-1:0] neg_src;
      logic               null_src;
      logic [RW+1:0]      rem_sh, trial;
      logic               ge;

      if (i == 0) begin : g_first
         assign valid_src = f2_valid_ff;
         assign v_src     = f2_v_ff;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign mag_src   = f2_mag_ff;
         assign neg_src   = f2_neg_ff;
         assign null_src  = f2_null_ff;
      end else begin : g_next
         assign valid_src = sq_valid_ff[i];
         assign v_src     = sq_v_ff[i];
         assign rem_src   = sq_rem_ff[i];
         assign root_src  = sq_root_ff[i];
         assign mag_src   = sq_mag_ff[i];
         assign neg_src   = sq_neg_ff[i];
         assign null_src  = sq_null_ff[i];
      end

      assign rem_sh = {rem_src[RW-1:0], v_src[VW-1 -: 2]};
      assign trial  = {root_src, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[i+1] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_v_ff[i+1]    <= {v_src[VW-3:0], 2'b00};
            sq_rem_ff[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
            sq_root_ff[i+1] <= {root_src[RW-2:0], ge};
            sq_mag_ff[i+1]  <= mag_src;
            sq_neg_ff[i+1]  <= neg_src;
            sq_null_ff[i+1] <= null_src;
         end
      end
   end

   // ---- three restoring dividers, one quotient bit per stage ----
   logic               dv_valid_ff [1:DS];
   logic [RW-1:0]      dv_root_ff  [1:DS];
   logic [NW-1:0]      dv_num_ff   [1:DS][NumComp];
   logic [QW-1:0]      dv_q_ff     [1:DS][NumComp];
   logic [NumComp-1:0] dv_neg_ff   [1:DS];
   logic               dv_null_ff  [1:DS];

   for (genvar j = 0; j < DS; j++) begin : g_div
      logic               valid_src;
      logic [RW-1:0]      root_src;
      logic [NW-1:0]      num_src [NumComp];
      logic [QW-1:0]      q_src   [NumComp];
      logic [NumComp-1:0] neg_src;
      logic               null_src;
      logic [NW-1:0]      dsr;

      if (j == 0) begin : g_first
         assign valid_src = sq_valid_ff[RW];
         assign root_src  = sq_root_ff[RW];
         assign neg_src   = sq_neg_ff[RW];
         assign null_src  = sq_null_ff[RW];
         for (genvar k = 0; k < NumComp; k++) begin : g_comp
            assign num_src[k] = {sq_mag_ff[RW][k], (2*F)'(0)};
            assign q_src[k]   = '0;
         end
      end else begin : g_next
         assign valid_src = dv_valid_ff[j];
         assign root_src  = dv_root_ff[j];
         assign neg_src   = dv_neg_ff[j];
         assign null_src  = dv_null_ff[j];
         assign num_src   = dv_num_ff[j];
         assign q_src     = dv_q_ff[j];
      end

      assign dsr = NW'(root_src) << (F - j);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j+1] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_root_ff[j+1] <= root_src;
            dv_neg_ff[j+1]  <= neg_src;
            dv_null_ff[j+1] <= null_src;
            for (int k = 0; k < NumComp; k++) begin
               if (num_src[k] >= dsr) begin
                  dv_num_ff[j+1][k] <= num_src[k] - dsr;
                  dv_q_ff[j+1][k]   <= {q_src[k][QW-2:0], 1'b1};
               end else begin
                  dv_num_ff[j+1][k] <= num_src[k];
                  dv_q_ff[j+1][k]   <= {q_src[k][QW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // ---- sign restore and output register ----
   logic [RspDw-1:0] out_data_in, out_data_ff;
   logic             out_null_ff;

   always_comb begin
      out_data_in = '0;
      for (int k = 0; k < NumComp; k++) begin
         if (dv_null_ff[DS]) begin
            out_data_in[k*OutW +: OutW] = '0;
         end else if (dv_neg_ff[DS][k]) begin
            out_data_in[k*OutW +: OutW] = ~OutW'(dv_q_ff[DS][k]) + OutW'(1);
         end else begin
            out_data_in[k*OutW +: OutW] = OutW'(dv_q_ff[DS][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
         out_null_ff <= dv_null_ff[DS];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_null_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
   import v3n_pkg::*;
();

   localparam int unsigned InW    = 16;
   localparam int unsigned FracW  = 14;
   localparam int unsigned OutW   = FracW + 2;
   localparam int unsigned ReqDw  = ((NumComp * InW + 7) / 8) * 8;
   localparam int unsigned RspDw  = ((NumComp * OutW + 7) / 8) * 8;
   localparam int unsigned Latency = InW + 2 * FracW + 5;
   localparam int unsigned NumRandom = 950;
   localparam int unsigned CycleLimit = 400000;

   typedef struct packed {
      logic [OutW-1:0] ux;
      logic [OutW-1:0] uy;
      logic [OutW-1:0] uz;
      logic            null_flag;
   } unit_vec_type;

   typedef struct {
      logic [InW-1:0] x;
      logic [InW-1:0] y;
      logic [InW-1:0] z;
      bit             known;   // expected result typed in below
      unit_vec_type   res;
   } vec_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [ReqDw-1:0] req_tdata = '0;   // x_in, y_in, z_in
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RspDw-1:0] rsp_tdata;        // unit_x, unit_y, unit_z
   logic             rsp_tuser;        // was_null

   unit_vec_type expected_units[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit          stim_done = 1'b0;
   bit          rx_idle_ok = 1'b1;   // random idling on the result side
   int unsigned hold_cycles = 0;     // long receiver hold-off request

   vector3_normalize #(.IN_WIDTH(InW), .OUT_FRAC_BITS(FracW)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // Bitwise normalizer: exact integer root and truncating quotient.
   function automatic unit_vec_type normalize_vec(logic [InW-1:0] x, logic [InW-1:0] y,
                                                  logic [InW-1:0] z);
      logic [InW-1:0]  comp [3];
      logic [InW:0]    mag  [3];
      logic [127:0]    sum_sq, scaled, rem, trial, root, q;
      logic [OutW-1:0] outc [3];
      unit_vec_type    r;
      comp[0] = x; comp[1] = y; comp[2] = z;
      sum_sq = '0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = comp[k][InW-1] ? ({1'b0, ~comp[k]} + (InW+1)'(1)) : {1'b0, comp[k]};
         sum_sq += 128'(mag[k]) * 128'(mag[k]);
      end
      if (sum_sq == 0) begin
         r = '{ux: '0, uy: '0, uz: '0, null_flag: 1'b1};
         return r;
      end
      scaled = sum_sq << (2 * FracW);
      rem = '0; root = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | 128'((scaled >> (2 * i)) & 3);
         trial = (root << 2) | 1;
         root = root << 1;
         if (rem >= trial) begin
            rem -= trial;
            root |= 1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         q = (128'(mag[k]) << (2 * FracW)) / root;
         if (comp[k][InW-1]) q = ~q + 1;
         outc[k] = q[OutW-1:0];
      end
      r = '{ux: outc[0], uy: outc[1], uz: outc[2], null_flag: 1'b0};
      return r;
   endfunction

   function automatic vec_row_type row(int x, int y, int z, bit known = 0,
                                       int ex = 0, int ey = 0, int ez = 0, bit nf = 0);
      vec_row_type v;
      v.x = x[InW-1:0]; v.y = y[InW-1:0]; v.z = z[InW-1:0];
      v.known = known;
      v.res = '{ux: ex[OutW-1:0], uy: ey[OutW-1:0], uz: ez[OutW-1:0], null_flag: nf};
      return v;
   endfunction

   // Sends one word; random idle before it unless the burst flag is set.
   task automatic send_vec(logic [InW-1:0] x, logic [InW-1:0] y, logic [InW-1:0] z,
                           bit burst);
      if (!burst) begin
         while ($urandom_range(99) < 19) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDw'({z, y, x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic queue_and_send(vec_row_type v, bit burst);
      expected_units.push_back(v.known ? v.res : normalize_vec(v.x, v.y, v.z));
      send_vec(v.x, v.y, v.z, burst);
   endtask

   function automatic logic [InW-1:0] rand_comp();
      case ($urandom_range(5))
         0: return InW'($urandom_range(7)) - InW'(3);     // near zero
         1: return {1'b1, {(InW-1){1'b0}}};               // most negative
         2: return {1'b0, {(InW-1){1'b1}}};               // most positive
         default: return InW'($urandom());
      endcase
   endfunction

   // Stimulus
   initial begin
      vec_row_type table_rows[$];
      vec_row_type v;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: null vector, single axis (unit results +-2^14), extremes, mixed.
      table_rows.push_back(row(0, 0, 0, 1, 0, 0, 0, 1));
      table_rows.push_back(row(4096, 0, 0, 1, 16384, 0, 0));
      table_rows.push_back(row(0, -4096, 0, 1, 0, -16384, 0));
      table_rows.push_back(row(0, 0, 1, 1, 0, 0, 16384));
      table_rows.push_back(row(-32768, 0, 0, 1, -16384, 0, 0));
      table_rows.push_back(row(0, 32767, 0, 1, 0, 16384, 0));
      table_rows.push_back(row(0, 0, -1, 1, 0, 0, -16384));
      table_rows.push_back(row(0, 0, -32768, 1, 0, 0, -16384));
      table_rows.push_back(row(-32768, -32768, -32768));
      table_rows.push_back(row(32767, 32767, 32767));
      table_rows.push_back(row(-32768, 32767, -32768));
      table_rows.push_back(row(1, 1, 1));
      table_rows.push_back(row(-1, 1, -1));
      table_rows.push_back(row(3, 4, 0));
      table_rows.push_back(row(1, 2, 2));
      table_rows.push_back(row(-32768, 1, 0));
      table_rows.push_back(row(12345, -6789, 1000));
      table_rows.push_back(row(0, 0, 0, 1, 0, 0, 0, 1));
      foreach (table_rows[i]) queue_and_send(table_rows[i], 1'b0);

      // Random, with a receiver hold-off while the sender keeps pushing.
      for (int n = 0; n < NumRandom; n++) begin
         if (n == 200) hold_cycles = 300;
         if (n == 500) begin
            // pause until the pipe has drained completely
            req_tvalid <= 1'b0;
            while (expected_units.size() != 0) @(posedge clock);
         end
         rx_idle_ok = !(n >= 600 && n < 750);
         v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
         v.known = 1'b0;
         if ($urandom_range(49) == 0) begin
            v.x = '0; v.y = '0; v.z = '0;
         end
         queue_and_send(v, n >= 600 && n < 750);
      end
      rx_idle_ok = 1'b1;
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // Result side ready generation.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         if (!rx_idle_ok)
            rsp_tready <= 1'b1;    // stretch with no idling
         else
            rsp_tready <= ($urandom_range(99) >= 19);
      end
   end

   // Checker
   always @(posedge clock) begin
      unit_vec_type got, exp_u;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{ux: rsp_tdata[OutW-1:0], uy: rsp_tdata[2*OutW-1:OutW],
                 uz: rsp_tdata[3*OutW-1:2*OutW], null_flag: rsp_tuser};
         if (expected_units.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %h", got);
         end else begin
            exp_u = expected_units.pop_front();
            if (got !== exp_u) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h z=%h n=%b got x=%h y=%h z=%h n=%b",
                           exp_u.ux, exp_u.uy, exp_u.uz, exp_u.null_flag,
                           got.ux, got.uy, got.uz, got.null_flag);
            end
         end
      end
   end

   // End of run and timeout.
   initial begin
      wait (stim_done);
      while (expected_units.size() != 0 && cycle_count < CycleLimit) @(posedge clock);
      if (cycle_count < CycleLimit) repeat (2 * Latency) @(posedge clock);
      if (cycle_count >= CycleLimit || expected_units.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit + 4 * Latency) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
sv/v3n_pkg.sv
sv/vector3_normalize.sv
sim/tb_top.sv
